/* src/tcw_pkg.sv */
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int CHAR_W       = 8;
    localparam int CELL_INDEX_W = 11;
    localparam int CELL_W       = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [CELL_W-1:0] TEXT_ATTR  = 16'h0700;

    localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic KIND_SERIAL = 1'b0;
    localparam logic KIND_CELL   = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [CHAR_W-1:0]       ch;
        logic [CELL_INDEX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } back_status_t;

endpackage

/* src/tcw_front.sv */
`timescale 1ns / 1ps
module tcw_front
    import tcw_pkg::*;
(
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [CHAR_W-1:0]       char_code,
    input  logic [CELL_INDEX_W-1:0] cell_index,
    input  back_status_t            status,
    input  logic                    q_full,
    output logic                    q_push,
    output cmd_t                    q_cmd
);

    logic is_cr;

    assign in_ready = !q_full && !status.clearing;
    assign is_cr    = (req_type == REQ_PUT) && (char_code == CHAR_CR);
    // drop carriage return here: it leaves no trace
    assign q_push   = in_valid && in_ready && !is_cr;

    always_comb
    begin
        q_cmd.ch  = char_code;
        q_cmd.idx = cell_index;
        if (req_type == REQ_READ)
        begin
            q_cmd.op = OP_READ;
        end
        else if (char_code == CHAR_LF)
        begin
            q_cmd.op = OP_NEWLINE;
        end
        else
        begin
            q_cmd.op = OP_PUT;
        end
    end

endmodule

/* src/tcw_queue.sv */
`timescale 1ns / 1ps
module tcw_queue
    import tcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t                entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/tcw_back.sv */
`timescale 1ns / 1ps
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output back_status_t      status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              result_kind,
    output logic [CHAR_W-1:0] serial_byte,
    output logic [CELL_W-1:0] cell_value,
    output logic              is_last
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int XW    = (AW + 1 > CELL_INDEX_W) ? AW + 1 : CELL_INDEX_W;

    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW   = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_MAX    = CW'(COLUMNS - 1);
    localparam logic [XW-1:0] CELLS_X    = XW'(CELLS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LF,
        ST_BLANK
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     cursor_reg;
    logic [AW-1:0]     cursor_next;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [AW-1:0]     base_reg;
    logic [AW-1:0]     base_next;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              kind_reg;
    logic              kind_next;
    logic [CHAR_W-1:0] byte_reg;
    logic [CHAR_W-1:0] byte_next;
    logic [CELL_W-1:0] cell_reg;
    logic [CELL_W-1:0] cell_next;
    logic              last_reg;
    logic              last_next;

    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [CELL_W-1:0] mem_wdata;
    logic              out_free;

    // map a row-relative position onto the circular screen memory
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] lin, input logic [AW-1:0] base);
        logic [AW:0] sum;
        sum = {1'b0, lin} + {1'b0, base};
        if (sum >= (AW+1)'(CELLS))
        begin
            sum = sum - (AW+1)'(CELLS);
        end
        return sum[AW-1:0];
    endfunction

    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign serial_byte = byte_reg;
    assign cell_value  = cell_reg;
    assign is_last     = last_reg;

    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.busy     = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        cell_next      = cell_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_addr       = addr_reg;
        mem_wdata      = BLANK_CELL;
        q_pop          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_CELL)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_READ:
                        begin
                            if (XW'(q_cmd.idx) < CELLS_X)
                            begin
                                mem_addr   = phys(AW'(q_cmd.idx), base_reg);
                                state_next = ST_READ;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = KIND_CELL;
                                byte_next      = '0;
                                cell_next      = '0;
                                last_next      = 1'b1;
                            end
                        end

                        OP_PUT:
                        begin
                            mem_we         = 1'b1;
                            mem_addr       = phys(cursor_reg, base_reg);
                            mem_wdata      = TEXT_ATTR | {8'h00, q_cmd.ch};
                            out_valid_next = 1'b1;
                            kind_next      = KIND_SERIAL;
                            byte_next      = q_cmd.ch;
                            cell_next      = '0;
                            last_next      = 1'b1;
                            if (cursor_reg == LAST_CELL)
                            begin
                                // past the end: recycle the top row as the bottom row
                                addr_next   = base_reg;
                                base_next   = phys(COLS_A, base_reg);
                                cursor_next = LAST_ROW;
                                col_next    = '0;
                                state_next  = ST_BLANK;
                            end
                            else
                            begin
                                cursor_next = cursor_reg + 1'b1;
                                col_next    = (col_reg == COL_MAX) ? '0 : col_reg + 1'b1;
                            end
                        end

                        OP_NEWLINE:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_SERIAL;
                            byte_next      = CHAR_CR;
                            cell_next      = '0;
                            last_next      = 1'b0;
                            state_next     = ST_LF;
                        end

                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                out_valid_next = 1'b1;
                kind_next      = KIND_CELL;
                byte_next      = '0;
                cell_next      = rd_data_reg;
                last_next      = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_LF:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_SERIAL;
                    byte_next      = CHAR_LF;
                    cell_next      = '0;
                    last_next      = 1'b1;
                    col_next       = '0;
                    if (cursor_reg >= LAST_ROW)
                    begin
                        addr_next   = base_reg;
                        base_next   = phys(COLS_A, base_reg);
                        cursor_next = LAST_ROW;
                        state_next  = ST_BLANK;
                    end
                    else
                    begin
                        cursor_next = cursor_reg - AW'(col_reg) + COLS_A;
                        state_next  = ST_IDLE;
                    end
                end
            end

            ST_BLANK:
            begin
                // sweep the new bottom row; the column counter wraps back to 0
                mem_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                col_next  = col_reg + 1'b1;
                if (col_reg == COL_MAX)
                begin
                    col_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cursor_reg    <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            byte_reg      <= '0;
            cell_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            byte_reg      <= byte_next;
            cell_reg      <= cell_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= screen_mem[mem_addr];
    end

endmodule

/* src/text_console_writer.sv */
`timescale 1ns / 1ps
// Text console of ROWS x COLUMNS cells (attribute 0x07 plus character) with a serial echo.
// After reset the screen memory is swept to blank, one cell a cycle; in_ready stays low
// meanwhile. Words enter a two-deep command queue; the executing side then writes a put
// straight to memory, answers a read from a registered read of the single-port screen
// memory and sends a newline as CR then LF. When the cursor runs past the last cell, or a
// newline lands on the bottom row, the recycled bottom row is blanked one cell a cycle.
// Scrolling only moves a row offset, so no screen contents are copied. Results leave
// through a registered output that may stall without stopping input until the queue fills.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    req_type,
    input  logic [CHAR_W-1:0]       char_code,
    input  logic [CELL_INDEX_W-1:0] cell_index,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    result_kind,
    output logic [CHAR_W-1:0]       serial_byte,
    output logic [CELL_W-1:0]       cell_value,
    output logic                    is_last
);

    back_status_t status;
    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_valid;
    cmd_t         push_cmd;
    cmd_t         head_cmd;

    tcw_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .char_code  (char_code),
        .cell_index (cell_index),
        .status     (status),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .serial_byte (serial_byte),
        .cell_value  (cell_value),
        .is_last     (is_last)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("command queue written while full");

    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !(in_valid && in_ready))
        else $error("word accepted during screen clear");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_valid && !status.busy))
        else $error("command taken while busy or queue empty");

    a_read_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_CELL) |-> (is_last && serial_byte == '0))
        else $error("malformed read result");
`endif

endmodule
